FILE: rtl/csc_pkg.sv
// shared types, constants and helpers of the cordic sine and cosine unit
package csc_pkg;

	localparam int AngleW = 32;
	localparam int OutW = 18;
	localparam int XyW = 20;
	localparam int ZW = 36;
	localparam int TW = 34;
	localparam int DefIterations = 16;
	localparam int TableLen = 17;

	localparam logic [29:0] PiReset = 30'd205887;
	localparam logic [30:0] TwoPiReset = 31'd411775;
	localparam logic [28:0] HalfPiReset = 29'd102944;
	localparam logic [16:0] GainReset = 17'd39797;

	typedef enum logic [1:0] {
		REG_PI = 2'd0,
		REG_TWO_PI = 2'd1,
		REG_HALF_PI = 2'd2,
		REG_GAIN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [AngleW-1:0] theta;
		logic [AngleW-1:0] mag;
		logic [AngleW-1:0] rem;
	} rem_t;

	typedef struct packed {
		logic signed [XyW-1:0] x;
		logic signed [XyW-1:0] y;
		logic signed [ZW-1:0] z;
		logic neg;
	} rot_t;

	function automatic logic signed [ZW-1:0] atan_q16(input int idx);
		logic signed [ZW-1:0] v;
		begin
			case (idx)
				0: v = ZW'(51471);
				1: v = ZW'(30385);
				2: v = ZW'(16061);
				3: v = ZW'(8152);
				4: v = ZW'(4093);
				default: v = ZW'(64'sd2048 >>> (idx - 5));
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [OutW-1:0] sat_out(input logic signed [XyW:0] v);
		logic signed [OutW-1:0] r;
		begin
			if (v > (XyW+1)'(131071))
				r = OutW'(131071);
			else if (v < -(XyW+1)'(131072))
				r = -OutW'(131072);
			else
				r = v[OutW-1:0];
			return r;
		end
	endfunction

endpackage

FILE: rtl/cordic_sine_cosine_q16_unit.sv
// top level of the pipelined cordic sine and cosine unit
// Takes one signed Q16.16 angle per cycle while the output is not stalled and
// returns its sine and cosine in signed Q1.16 once the item has passed every
// stage. The input register takes the item at the accepting edge; after it
// come the 32-cell remainder chain for the modulo two pi reduction, four fold
// stages, one cordic cell per iteration (capped at the table length) and the
// output register. Every stage has its own valid bit, so bubbles collapse and
// a stalled output does not stop new items while earlier stages have room.
// Configuration writes must happen while the pipeline is empty.
module cordic_sine_cosine_q16_unit #(
	parameter int ITERATIONS = csc_pkg::DefIterations
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [30:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] angle,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [17:0] sine,
	output logic signed [17:0] cosine
);
	import csc_pkg::*;

	localparam int NIter = (ITERATIONS > TableLen) ? TableLen : ITERATIONS;
	localparam int RemBase = 1;
	localparam int FoldBase = RemBase + AngleW;
	localparam int RotBase = FoldBase + 4;
	localparam int OutStage = RotBase + NIter;
	localparam int NS = OutStage + 1;

	logic [29:0] pi_q;
	logic [30:0] two_pi_q;
	logic [28:0] half_pi_q;
	logic [16:0] gain_q;

	logic [NS-1:0] v_q;
	logic [NS:0] rdy;
	logic [NS-1:0] vin;

	rem_t prep_s1;
	rem_t rem_d [AngleW+1];
	rot_t rot_d [NIter+1];
	logic signed [XyW:0] xf;
	logic signed [OutW-1:0] sine_s1, cosine_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q <= PiReset;
			two_pi_q <= TwoPiReset;
			half_pi_q <= HalfPiReset;
			gain_q <= GainReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PI: pi_q <= cfg_wdata[29:0];
				REG_TWO_PI: two_pi_q <= cfg_wdata;
				REG_HALF_PI: half_pi_q <= cfg_wdata[28:0];
				REG_GAIN: gain_q <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// ready chain from the output back to the input
	always_comb begin
		rdy[NS] = out_ready;
		for (int i = NS - 1; i >= 0; i--)
			rdy[i] = !v_q[i] || rdy[i+1];
		vin[0] = in_valid;
		for (int i = 1; i < NS; i++)
			vin[i] = v_q[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else begin
			for (int i = 0; i < NS; i++)
				if (rdy[i])
					v_q[i] <= vin[i];
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			prep_s1.theta <= angle;
			prep_s1.mag <= angle[AngleW-1] ? AngleW'(-angle) : AngleW'(angle);
			prep_s1.rem <= '0;
		end
	end

	assign rem_d[0] = prep_s1;

	for (genvar g = 0; g < AngleW; g++) begin : g_rem
		csc_rem_cell u_rem (
			.clk(clk),
			.en(rdy[RemBase+g]),
			.divisor(two_pi_q),
			.din(rem_d[g]),
			.dout(rem_d[g+1])
		);
	end

	csc_fold u_fold (
		.clk(clk),
		.en(rdy[FoldBase+3:FoldBase]),
		.pi_value(pi_q),
		.two_pi_value(two_pi_q),
		.half_pi_value(half_pi_q),
		.gain_value(gain_q),
		.din(rem_d[AngleW]),
		.dout(rot_d[0])
	);

	for (genvar g = 0; g < NIter; g++) begin : g_rot
		csc_rot_cell #(.IDX(g)) u_rot (
			.clk(clk),
			.en(rdy[RotBase+g]),
			.din(rot_d[g]),
			.dout(rot_d[g+1])
		);
	end

	assign xf = rot_d[NIter].neg ? -(XyW+1)'(rot_d[NIter].x) : (XyW+1)'(rot_d[NIter].x);

	always_ff @(posedge clk) begin
		if (rdy[OutStage]) begin
			sine_s1 <= sat_out((XyW+1)'(rot_d[NIter].y));
			cosine_s1 <= sat_out(xf);
		end
	end

	assign sine = sine_s1;
	assign cosine = cosine_s1;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q == '0) |-> in_ready)
		else $error("input stalled with empty pipeline");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sine) && $stable(cosine)))
		else $error("stalled result changed");
endmodule

FILE: rtl/csc_rem_cell.sv
// one restoring remainder cell, one dividend bit per cycle while enabled
module csc_rem_cell (
	input  logic clk,
	input  logic en,
	input  logic [30:0] divisor,
	input  csc_pkg::rem_t din,
	output csc_pkg::rem_t dout
);
	import csc_pkg::*;

	rem_t data_s1;
	logic [AngleW-1:0] trial;
	rem_t nxt;

	always_comb begin
		trial = {din.rem[AngleW-2:0], din.mag[AngleW-1]};
		nxt.theta = din.theta;
		nxt.mag = {din.mag[AngleW-2:0], 1'b0};
		if (trial >= {1'b0, divisor})
			nxt.rem = trial - {1'b0, divisor};
		else
			nxt.rem = trial;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

	assign dout = data_s1;
endmodule

FILE: rtl/csc_fold.sv
// sign restore, wrap into minus pi to pi and reflection into half pi range
module csc_fold (
	input  logic clk,
	input  logic [3:0] en,
	input  logic [29:0] pi_value,
	input  logic [30:0] two_pi_value,
	input  logic [28:0] half_pi_value,
	input  logic [16:0] gain_value,
	input  csc_pkg::rem_t din,
	output csc_pkg::rot_t dout
);
	import csc_pkg::*;

	logic signed [TW-1:0] t_s1, t_s2, t_s3;
	logic signed [TW-1:0] pi_s, tpi_s, hpi_s;
	logic signed [TW-1:0] r_s;
	rot_t out_s4;

	assign pi_s = TW'({1'b0, pi_value});
	assign tpi_s = TW'({1'b0, two_pi_value});
	assign hpi_s = TW'({1'b0, half_pi_value});
	assign r_s = TW'({1'b0, din.rem});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			if (two_pi_value == '0)
				t_s1 <= TW'(din.theta);
			else if (din.theta[AngleW-1])
				t_s1 <= -r_s;
			else
				t_s1 <= r_s;
		end
		if (en[1])
			t_s2 <= (t_s1 > pi_s) ? t_s1 - tpi_s : t_s1;
		if (en[2])
			t_s3 <= (t_s2 < -pi_s) ? t_s2 + tpi_s : t_s2;
		if (en[3]) begin
			out_s4.x <= XyW'({1'b0, gain_value});
			out_s4.y <= '0;
			if (t_s3 > hpi_s) begin
				out_s4.z <= ZW'(pi_s - t_s3);
				out_s4.neg <= 1'b1;
			end else if (t_s3 < -hpi_s) begin
				out_s4.z <= ZW'(-pi_s - t_s3);
				out_s4.neg <= 1'b1;
			end else begin
				out_s4.z <= ZW'(t_s3);
				out_s4.neg <= 1'b0;
			end
		end
	end

	assign dout = out_s4;
endmodule

FILE: rtl/csc_rot_cell.sv
// one rotation-mode cordic cell for a fixed step index
module csc_rot_cell #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic en,
	input  csc_pkg::rot_t din,
	output csc_pkg::rot_t dout
);
	import csc_pkg::*;

	localparam logic signed [ZW-1:0] Atan = atan_q16(IDX);

	rot_t data_s1;
	logic signed [XyW-1:0] xs, ys;

	assign xs = din.x >>> IDX;
	assign ys = din.y >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.neg <= din.neg;
			if (!din.z[ZW-1]) begin
				data_s1.x <= din.x - ys;
				data_s1.y <= din.y + xs;
				data_s1.z <= din.z - Atan;
			end else begin
				data_s1.x <= din.x + ys;
				data_s1.y <= din.y - xs;
				data_s1.z <= din.z + Atan;
			end
		end
	end

	assign dout = data_s1;
endmodule
